### hw/rtl/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  // ALU operation codes
  localparam logic [3:0] FN_AND = 4'd0;
  localparam logic [3:0] FN_EOR = 4'd1;
  localparam logic [3:0] FN_SUB = 4'd2;
  localparam logic [3:0] FN_RSB = 4'd3;
  localparam logic [3:0] FN_ADD = 4'd4;
  localparam logic [3:0] FN_ADC = 4'd5;
  localparam logic [3:0] FN_SBC = 4'd6;
  localparam logic [3:0] FN_RSC = 4'd7;
  localparam logic [3:0] FN_TST = 4'd8;
  localparam logic [3:0] FN_TEQ = 4'd9;
  localparam logic [3:0] FN_CMP = 4'd10;
  localparam logic [3:0] FN_CMN = 4'd11;
  localparam logic [3:0] FN_ORR = 4'd12;
  localparam logic [3:0] FN_MOV = 4'd13;
  localparam logic [3:0] FN_BIC = 4'd14;
  localparam logic [3:0] FN_MVN = 4'd15;

  // Operand forms
  localparam logic [1:0] FORM_IMM_SHIFT = 2'd0;
  localparam logic [1:0] FORM_REG_SHIFT = 2'd1;

  // Shift types as encoded in the word
  localparam logic [1:0] SHT_LSL = 2'd0;
  localparam logic [1:0] SHT_LSR = 2'd1;
  localparam logic [1:0] SHT_ASR = 2'd2;
  localparam logic [1:0] SHT_ROR = 2'd3;

  // Internal shifter operations
  localparam logic [2:0] KIND_LSL = 3'd0;
  localparam logic [2:0] KIND_LSR = 3'd1;
  localparam logic [2:0] KIND_ASR = 3'd2;
  localparam logic [2:0] KIND_ROR = 3'd3;
  localparam logic [2:0] KIND_RRX = 3'd4;

  localparam int unsigned WordW = 32;

  typedef struct packed {
    logic [3:0]       func;
    logic [1:0]       operand_form;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic [1:0]       shift_type;
    logic [7:0]       shift_amount;
    logic [11:0]      imm_field;
    logic             c_flag_in;
    logic             overflow_in;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic             flag_n;
    logic             flag_z;
    logic             flag_c;
    logic             flag_v;
    logic             writes_result;
  } out_t;

endpackage

`default_nettype wire

### hw/rtl/barrel_shifter_alu_top.sv
// Throughput: one word per cycle while out_stall_i is low; the four
// stages are decode, barrel shift, ALU and flags, each with its own valid
// bit and ready, so bubbles close up.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload
// registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module barrel_shifter_alu_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bsa_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bsa_pkg::out_t      out_data_o
);
  import bsa_pkg::*;

  typedef struct packed {
    logic [3:0]       func;
    logic [WordW-1:0] a;
    logic [WordW-1:0] value;
    logic [2:0]       kind;
    logic [7:0]       amt;
    logic             cin;
    logic             vin;
  } dec_t;

  typedef struct packed {
    logic [3:0]       func;
    logic [WordW-1:0] a;
    logic [WordW-1:0] op2;
    logic             sh_c;
    logic             cin;
    logic             vin;
  } shf_t;

  typedef struct packed {
    logic [WordW-1:0] res;
    logic             c;
    logic             v;
    logic             wr;
  } alu_t;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  dec_t s1_d, s1_q;
  shf_t s2_d, s2_q;
  alu_t s3_d, s3_q;
  out_t s4_d, s4_q;

  // Each stage takes a word when empty or when the next one drains
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;
  assign out_data_o  = s4_q;

  // Stage 1: decode operand form into shifter operation and amount
  always_comb begin
    s1_d.func  = in_data_i.func;
    s1_d.a     = in_data_i.operand_a;
    s1_d.cin   = in_data_i.c_flag_in;
    s1_d.vin   = in_data_i.overflow_in;
    s1_d.value = in_data_i.operand_b;
    s1_d.kind  = {1'b0, in_data_i.shift_type};
    s1_d.amt   = in_data_i.shift_amount;
    case (in_data_i.operand_form)
      FORM_IMM_SHIFT: begin
        s1_d.amt = {3'b000, in_data_i.shift_amount[4:0]};
        if (in_data_i.shift_amount[4:0] == 5'd0) begin
          if (in_data_i.shift_type == SHT_LSR || in_data_i.shift_type == SHT_ASR) begin
            s1_d.amt = 8'd32;
          end else if (in_data_i.shift_type == SHT_ROR) begin
            s1_d.kind = KIND_RRX;
          end
        end
      end
      FORM_REG_SHIFT: begin
        s1_d.amt = in_data_i.shift_amount;
      end
      default: begin
        // rotated immediate, also for the undefined form
        s1_d.value = {24'd0, in_data_i.imm_field[7:0]};
        s1_d.kind  = KIND_ROR;
        s1_d.amt   = {3'b000, in_data_i.imm_field[11:8], 1'b0};
      end
    endcase
  end

  // Stage 2: barrel shifter and shifter carry
  logic [WordW:0]     lsl_ext, lsr_ext, asr_ext;
  logic [2*WordW-1:0] ror_ext;
  logic [4:0]         sh5;
  logic               big, eq32;

  always_comb begin
    sh5     = s1_q.amt[4:0];
    big     = s1_q.amt >= 8'd32;
    eq32    = s1_q.amt == 8'd32;
    lsl_ext = {1'b0, s1_q.value} << sh5;
    lsr_ext = {s1_q.value, 1'b0} >> sh5;
    asr_ext = $unsigned($signed({s1_q.value, 1'b0}) >>> sh5);
    ror_ext = {s1_q.value, s1_q.value} >> sh5;

    s2_d.func = s1_q.func;
    s2_d.a    = s1_q.a;
    s2_d.cin  = s1_q.cin;
    s2_d.vin  = s1_q.vin;
    s2_d.op2  = s1_q.value;
    s2_d.sh_c = s1_q.cin;
    if (s1_q.kind == KIND_RRX) begin
      s2_d.op2  = {s1_q.cin, s1_q.value[WordW-1:1]};
      s2_d.sh_c = s1_q.value[0];
    end else if (s1_q.amt != 8'd0) begin
      case (s1_q.kind)
        KIND_LSL: begin
          if (big) begin
            s2_d.op2  = '0;
            s2_d.sh_c = eq32 & s1_q.value[0];
          end else begin
            s2_d.op2  = lsl_ext[WordW-1:0];
            s2_d.sh_c = lsl_ext[WordW];
          end
        end
        KIND_LSR: begin
          if (big) begin
            s2_d.op2  = '0;
            s2_d.sh_c = eq32 & s1_q.value[WordW-1];
          end else begin
            s2_d.op2  = lsr_ext[WordW:1];
            s2_d.sh_c = lsr_ext[0];
          end
        end
        KIND_ASR: begin
          if (big) begin
            s2_d.op2  = {WordW{s1_q.value[WordW-1]}};
            s2_d.sh_c = s1_q.value[WordW-1];
          end else begin
            s2_d.op2  = asr_ext[WordW:1];
            s2_d.sh_c = asr_ext[0];
          end
        end
        default: begin
          s2_d.op2  = ror_ext[WordW-1:0];
          s2_d.sh_c = ror_ext[WordW-1];
        end
      endcase
    end
  end

  // Stage 3: ALU
  logic [WordW-1:0] add_x, add_y, logic_r;
  logic             add_ci, is_arith;
  logic [WordW:0]   sum;

  always_comb begin
    add_x    = s2_q.a;
    add_y    = s2_q.op2;
    add_ci   = 1'b0;
    is_arith = 1'b1;
    logic_r  = '0;
    case (s2_q.func)
      FN_SUB, FN_CMP: begin
        add_y  = ~s2_q.op2;
        add_ci = 1'b1;
      end
      FN_RSB: begin
        add_x  = ~s2_q.a;
        add_ci = 1'b1;
      end
      FN_ADD, FN_CMN: add_ci = 1'b0;
      FN_ADC: add_ci = s2_q.cin;
      FN_SBC: begin
        add_y  = ~s2_q.op2;
        add_ci = s2_q.cin;
      end
      FN_RSC: begin
        add_x  = ~s2_q.a;
        add_ci = s2_q.cin;
      end
      FN_AND, FN_TST: begin
        is_arith = 1'b0;
        logic_r  = s2_q.a & s2_q.op2;
      end
      FN_EOR, FN_TEQ: begin
        is_arith = 1'b0;
        logic_r  = s2_q.a ^ s2_q.op2;
      end
      FN_ORR: begin
        is_arith = 1'b0;
        logic_r  = s2_q.a | s2_q.op2;
      end
      FN_MOV: begin
        is_arith = 1'b0;
        logic_r  = s2_q.op2;
      end
      FN_BIC: begin
        is_arith = 1'b0;
        logic_r  = s2_q.a & ~s2_q.op2;
      end
      default: begin
        is_arith = 1'b0;
        logic_r  = ~s2_q.op2;
      end
    endcase
    sum = {1'b0, add_x} + {1'b0, add_y} + {{WordW{1'b0}}, add_ci};

    if (is_arith) begin
      s3_d.res = sum[WordW-1:0];
      s3_d.c   = sum[WordW];
      s3_d.v   = (add_x[WordW-1] ^ sum[WordW-1]) & (add_y[WordW-1] ^ sum[WordW-1]);
    end else begin
      s3_d.res = logic_r;
      s3_d.c   = s2_q.sh_c;
      s3_d.v   = s2_q.vin;
    end
    s3_d.wr = !(s2_q.func == FN_TST || s2_q.func == FN_TEQ ||
                s2_q.func == FN_CMP || s2_q.func == FN_CMN);
  end

  // Stage 4: flags and output word
  always_comb begin
    s4_d.result        = s3_q.res;
    s4_d.flag_n        = s3_q.res[WordW-1];
    s4_d.flag_z        = s3_q.res == '0;
    s4_d.flag_c        = s3_q.c;
    s4_d.flag_v        = s3_q.v;
    s4_d.writes_result = s3_q.wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Payload: load only a valid word into a stage that can take it
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
    if (rdy4 && v3_q)       s4_q <= s4_d;
  end

endmodule

`default_nettype wire
